// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the pose update RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// plain property, clocked on rising edge, off during reset
`define MPU_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// overlapping implication
`define MPU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define MPU_ASSERT(label, clk, rst_n, prop)
`define MPU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/mpu_pkg.sv =====
// Package: widths, CORDIC constants and shared types of the pose update block.
package mpu_pkg;

	localparam int DELTA_W     = 12;
	localparam int SUM_W       = DELTA_W + 2;
	localparam int RANGE_W     = 31;
	localparam int ANGLE_W     = 16;
	localparam int POS_W       = 32;
	localparam int SCALE_W     = 16;
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 80;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd10430;

	localparam int QUARTER_TURN = 16384;
	localparam int HALF_TURN    = 32768;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int STEP_W       = (CORDIC_N > 1) ? $clog2(CORDIC_N) : 1;
	localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

	localparam int CV_W      = 33;
	localparam int CZ_W      = 34;
	localparam int CV_SHIFT  = 14;
	localparam int TRIG_W    = 18;

	localparam logic signed [CV_W-1:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = TRIG_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 1;

	typedef struct packed {
		logic               start;
		logic [ANGLE_W-1:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} trig_t;

endpackage

// ===== rtl/mpu_cordic.sv =====
// Iterative rotation-mode CORDIC: Q16 cosine and sine of a binary angle.
`include "assert_macros.svh"

module mpu_cordic import mpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cordic_req_t req,
	output trig_t       trig
);

	typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

	cstate_t                 state_q;
	logic [STEP_W-1:0]       step_q;
	logic signed [CV_W-1:0]  x_q, y_q;
	logic signed [CZ_W-1:0]  z_q;
	logic                    flip_q;

	logic signed [ANGLE_W:0] a_ext, a_fold;
	logic                    flip;
	logic signed [CZ_W-1:0]  z_init, atan_v, z_n;
	logic signed [CV_W-1:0]  xs, ys, x_n, y_n, x_bias, y_bias, x_rsh, y_rsh;
	logic signed [TRIG_W-1:0] x_r, y_r;

	// fold into [-quarter, quarter] turn
	always_comb begin
		a_ext = {req.angle[ANGLE_W-1], req.angle};
		flip  = 1'b0;
		a_fold = a_ext;
		if (a_ext > QUARTER_TURN) begin
			a_fold = (ANGLE_W+1)'(a_ext - HALF_TURN);
			flip   = 1'b1;
		end else if (a_ext < -QUARTER_TURN) begin
			a_fold = (ANGLE_W+1)'(a_ext + HALF_TURN);
			flip   = 1'b1;
		end
		z_init = {{(CZ_W-2*ANGLE_W-1){a_fold[ANGLE_W]}}, a_fold, {ANGLE_W{1'b0}}};
	end

	always_comb begin
		xs     = x_q >>> step_q;
		ys     = y_q >>> step_q;
		atan_v = CZ_W'(ATAN_TURNS[ATAN_IDX_W'(step_q)]);
		if (!z_q[CZ_W-1]) begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - atan_v;
		end else begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + atan_v;
		end
	end

	// Q30 -> Q16, half away from zero
	always_comb begin
		x_bias = x_q + CV_W'(1 << (CV_SHIFT-1)) - CV_W'(x_q[CV_W-1]);
		y_bias = y_q + CV_W'(1 << (CV_SHIFT-1)) - CV_W'(y_q[CV_W-1]);
		x_rsh  = x_bias >>> CV_SHIFT;
		y_rsh  = y_bias >>> CV_SHIFT;
		x_r    = TRIG_W'(x_rsh);
		y_r    = TRIG_W'(y_rsh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= C_IDLE;
			trig.done <= 1'b0;
		end else begin
			trig.done <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (req.start) begin
						x_q     <= CORDIC_GAIN;
						y_q     <= '0;
						z_q     <= z_init;
						flip_q  <= flip;
						step_q  <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					x_q <= x_n;
					y_q <= y_n;
					z_q <= z_n;
					if (step_q == STEP_W'(CORDIC_N-1)) begin
						state_q <= C_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				C_FIN: begin
					trig.cos_v <= flip_q ? -x_r : x_r;
					trig.sin_v <= flip_q ? -y_r : y_r;
					trig.done  <= 1'b1;
					state_q    <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	`MPU_ASSERT_IMP(a_start_when_idle, clk, arst_n, req.start, state_q == C_IDLE)
	`MPU_ASSERT(a_done_pulse, clk, arst_n, trig.done |=> !trig.done)
	`MPU_ASSERT_IMP(a_done_after_fin, clk, arst_n, trig.done, $past(state_q) == C_FIN)

endmodule

// ===== rtl/mpu_mul.sv =====
// Shared registered signed multiplier.
module mpu_mul import mpu_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]  prod
);

	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

// ===== rtl/mecanum_pose_update_core.sv =====
// Top level: mecanum dead-reckoning pose keeper with position fix.
//
// Input items arrive on s_axis_*; tuser is the action (0 wheel update, 1 polar fix).
// Each accepted item produces exactly one result item on m_axis_*, carrying the new
// x, y, heading and a saturation flag in tuser.
// heading_scale is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is always high.
//
// One item is processed at a time by a sequencer driving one CORDIC unit and one
// shared multiplier. A wheel item runs the heading product and update, the CORDIC and
// four products into x and y; a fix item runs the CORDIC and two range products. Both
// end in a clip state that loads the output register, then the sequencer goes idle.
// The result sits in an output register; a new item may be accepted while it waits,
// and a finished result stalls in the sequencer until the register is free.
// Reset clears the pose to zero, heading_scale to 10430, and drops tvalid.
`include "assert_macros.svh"

module mecanum_pose_update_core import mpu_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// lb[11:0] lf[23:12] rb[35:24] rf[47:36] fix_range[78:48] fix_angle[94:79] pad[95]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// action[0]
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// pos_x[31:0] pos_y[63:32] heading_out[79:64]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// saturated[0]
	output logic                   m_axis_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [SCALE_W-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_H, ST_HEAD, ST_CSTART, ST_CWAIT,
		ST_MX1, ST_MX2, ST_MY1, ST_MY2, ST_YFIN,
		ST_FX, ST_FY, ST_FR, ST_CLIP
	} state_t;

	state_t                     state_q;
	logic                       action_q;
	logic signed [DELTA_W-1:0]  dh_q, dx_q, dy_q;
	logic [RANGE_W-1:0]         range_q;
	logic [ANGLE_W-1:0]         angle_q;
	logic [SCALE_W-1:0]         scale_q;
	logic [ANGLE_W-1:0]         heading_q;
	logic signed [POS_W-1:0]    x_q, y_q;
	logic signed [ACC_W-1:0]    ax_q, ay_q;

	logic                       in_acc;
	logic                       out_load;
	logic signed [SUM_W-1:0]    lb, lf, rb, rf, sum_h, sum_x, sum_y;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [ACC_W-1:0]    rnd_sum, fix_round;
	logic signed [POS_W-1:0]    x_clip, y_clip;
	logic                       x_sat, y_sat;
	cordic_req_t                creq;
	trig_t                      trig;

	function automatic logic signed [DELTA_W-1:0] quarter_tz(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] t;
		t = v + (v[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
		return DELTA_W'(t >>> 2);
	endfunction

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_CLIP) && (!m_axis_tvalid || m_axis_tready);
	assign cfg_ready     = 1'b1;

	always_comb begin
		lb    = SUM_W'($signed(s_axis_tdata[11:0]));
		lf    = SUM_W'($signed(s_axis_tdata[23:12]));
		rb    = SUM_W'($signed(s_axis_tdata[35:24]));
		rf    = SUM_W'($signed(s_axis_tdata[47:36]));
		sum_h = lb + lf + rb + rf;
		sum_x = lf + rf - lb - rb;
		sum_y = lb + lf - rf - rb;
	end

	always_comb begin
		mul_a = MUL_A_W'(dy_q);
		mul_b = trig.cos_v;
		case (state_q)
			ST_MUL_H: begin
				mul_a = MUL_A_W'(dh_q);
				mul_b = signed'(MUL_B_W'(scale_q));
			end
			ST_MX2: begin
				mul_a = MUL_A_W'(dx_q);
				mul_b = trig.sin_v;
			end
			ST_MY1: mul_b = trig.sin_v;
			ST_MY2: mul_a = MUL_A_W'(dx_q);
			ST_FX: mul_a = signed'(MUL_A_W'(range_q));
			ST_FY: begin
				mul_a = signed'(MUL_A_W'(range_q));
				mul_b = trig.sin_v;
			end
			default: ;
		endcase
	end

	mpu_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign creq.start = (state_q == ST_CSTART);
	assign creq.angle = action_q ? angle_q : heading_q;

	mpu_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.trig   (trig)
	);

	// Q18.32 -> Q16.16, half away from zero
	always_comb begin
		rnd_sum   = ACC_W'(prod) + ACC_W'(1 << 15) - ACC_W'(prod[PROD_W-1]);
		fix_round = rnd_sum >>> 16;
	end

	always_comb begin
		x_sat  = (ax_q[ACC_W-1:POS_W-1] != '0) && (ax_q[ACC_W-1:POS_W-1] != '1);
		y_sat  = (ay_q[ACC_W-1:POS_W-1] != '0) && (ay_q[ACC_W-1:POS_W-1] != '1);
		x_clip = POS_W'(ax_q);
		y_clip = POS_W'(ay_q);
		if (x_sat) begin
			x_clip = ax_q[ACC_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end
		if (y_sat) begin
			y_clip = ay_q[ACC_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			m_axis_tvalid <= 1'b0;
			heading_q     <= '0;
			x_q           <= '0;
			y_q           <= '0;
		end else begin
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						action_q <= s_axis_tuser;
						dh_q     <= quarter_tz(sum_h);
						dx_q     <= quarter_tz(sum_x);
						dy_q     <= quarter_tz(sum_y);
						range_q  <= s_axis_tdata[78:48];
						angle_q  <= s_axis_tdata[94:79];
						state_q  <= s_axis_tuser ? ST_CSTART : ST_MUL_H;
					end
				end
				ST_MUL_H: state_q <= ST_HEAD;
				ST_HEAD: begin
					heading_q <= heading_q - prod[ANGLE_W-1:0];
					state_q   <= ST_CSTART;
				end
				ST_CSTART: state_q <= ST_CWAIT;
				ST_CWAIT: begin
					if (trig.done) begin
						state_q <= action_q ? ST_FX : ST_MX1;
					end
				end
				ST_MX1: state_q <= ST_MX2;
				ST_MX2: begin
					ax_q    <= ACC_W'(x_q) + ACC_W'(prod);
					state_q <= ST_MY1;
				end
				ST_MY1: begin
					ax_q    <= ax_q + ACC_W'(prod);
					state_q <= ST_MY2;
				end
				ST_MY2: begin
					ay_q    <= ACC_W'(y_q) + ACC_W'(prod);
					state_q <= ST_YFIN;
				end
				ST_YFIN: begin
					ay_q    <= ay_q - ACC_W'(prod);
					state_q <= ST_CLIP;
				end
				ST_FX: state_q <= ST_FY;
				ST_FY: begin
					ax_q    <= fix_round;
					state_q <= ST_FR;
				end
				ST_FR: begin
					ay_q    <= fix_round;
					state_q <= ST_CLIP;
				end
				ST_CLIP: begin
					if (out_load) begin
						x_q          <= x_clip;
						y_q          <= y_clip;
						m_axis_tdata <= {heading_q, y_clip, x_clip};
						m_axis_tuser <= x_sat || y_sat;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MPU_ASSERT(a_one_item_at_a_time, clk, arst_n,
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
	`MPU_ASSERT(a_fix_keeps_heading, clk, arst_n,
		(action_q && state_q != ST_IDLE) |=> $stable(heading_q))
	`MPU_ASSERT_IMP(a_sat_at_limit, clk, arst_n, m_axis_tvalid && m_axis_tuser,
		m_axis_tdata[31:0] == 32'h7FFFFFFF || m_axis_tdata[31:0] == 32'h80000000 ||
		m_axis_tdata[63:32] == 32'h7FFFFFFF || m_axis_tdata[63:32] == 32'h80000000)

endmodule
